// ===== rtl/tdu_pkg.sv =====
// tdu_pkg: shared types, opcodes and pixel helpers of the tft display unpacker
// used by tdu_front, tdu_queue, tdu_back and the top level
`timescale 1ns / 1ps
`default_nettype none

package tdu_pkg;

  // frame limits applied to the configured width and height
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int FRAME_DIM_W  = 9;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [FRAME_DIM_W-1:0] FRAME_WIDTH_RST  = 9'd128;
  localparam logic [FRAME_DIM_W-1:0] FRAME_HEIGHT_RST = 9'd160;

  // register index, taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // request kinds
  localparam logic REQ_CMD  = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  // command opcodes
  localparam logic [7:0] OP_NONE      = 8'h00;
  localparam logic [7:0] OP_SW_RESET  = 8'h01;
  localparam logic [7:0] OP_SLEEP_IN  = 8'h10;
  localparam logic [7:0] OP_SLEEP_OUT = 8'h11;
  localparam logic [7:0] OP_INV_OFF   = 8'h20;
  localparam logic [7:0] OP_INV_ON    = 8'h21;
  localparam logic [7:0] OP_DISP_OFF  = 8'h28;
  localparam logic [7:0] OP_DISP_ON   = 8'h29;
  localparam logic [7:0] OP_COL_SET   = 8'h2A;
  localparam logic [7:0] OP_ROW_SET   = 8'h2B;
  localparam logic [7:0] OP_RAM_WR    = 8'h2C;
  localparam logic [7:0] OP_IDLE_OFF  = 8'h38;
  localparam logic [7:0] OP_IDLE_ON   = 8'h39;
  localparam logic [7:0] OP_PIX_FMT   = 8'h3A;
  localparam logic [7:0] OP_SRC_DIR   = 8'hB7;
  localparam logic [7:0] OP_GATE_DIR  = 8'hB8;

  // pixel formats
  localparam logic [2:0] FMT_12BIT = 3'd3;
  localparam logic [2:0] FMT_16BIT = 3'd5;
  localparam logic [2:0] FMT_18BIT = 3'd6;

  typedef struct packed {
    logic sleep;
    logic idle;
    logic invert;
    logic flip_x;
    logic flip_y;
  } tdu_status_t;

  // one decoded item: up to two pixel candidates plus status
  typedef struct packed {
    logic [1:0]  npix;
    logic [15:0] x0;
    logic [15:0] x1;
    logic [15:0] y;
    logic [7:0]  r0;
    logic [7:0]  g0;
    logic [7:0]  b0;
    logic [7:0]  r1;
    logic [7:0]  g1;
    logic [7:0]  b1;
    logic        clr;
    tdu_status_t st;
  } tdu_entry_t;

  typedef struct packed {
    logic        pixel_write;
    logic [15:0] pixel_addr;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
    logic        clear_frame;
    tdu_status_t st;
  } tdu_result_t;

  function automatic logic [7:0] rep4hi(input logic [7:0] b);
    return {b[7:4], b[7:4]};
  endfunction

  function automatic logic [7:0] rep4lo(input logic [7:0] b);
    return {b[3:0], b[3:0]};
  endfunction

  // big-endian half update: even byte index writes the upper byte
  function automatic logic [15:0] put_half(input logic [15:0] word, input logic [7:0] b,
                                           input logic [2:0] n);
    if (n[0] == 1'b0) begin
      return {b, word[7:0]};
    end
    return {word[15:8], b};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tdu_front.sv =====
// tdu_front: command/data decoder, window and cursor state, pixel gathering
// depends on tdu_pkg; produces one tdu_entry_t per accepted item
`timescale 1ns / 1ps
`default_nettype none

module tdu_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic               req_type,
  input  wire logic [7:0]         byte_value,
  output tdu_pkg::tdu_entry_t     entry
);
  import tdu_pkg::*;

  logic [7:0]  cmd_r, cmd_nxt;
  logic [2:0]  bc_r, bc_nxt;
  logic [15:0] col_start_r, col_start_nxt, col_end_r, col_end_nxt;
  logic [15:0] row_start_r, row_start_nxt, row_end_r, row_end_nxt;
  logic [15:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [1:0]  gc_r, gc_nxt;
  logic [7:0]  gb0_r, gb0_nxt, gb1_r, gb1_nxt, gb2_r, gb2_nxt;
  logic [2:0]  fmt_r, fmt_nxt;
  tdu_status_t st_r, st_nxt;

  logic [1:0]  gi, gcn;
  logic        complete;
  logic [15:0] cx_adv, cy_inc;

  always_comb begin
    cmd_nxt       = cmd_r;
    bc_nxt        = bc_r;
    col_start_nxt = col_start_r;
    col_end_nxt   = col_end_r;
    row_start_nxt = row_start_r;
    row_end_nxt   = row_end_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    gc_nxt        = gc_r;
    gb0_nxt       = gb0_r;
    gb1_nxt       = gb1_r;
    gb2_nxt       = gb2_r;
    fmt_nxt       = fmt_r;
    st_nxt        = st_r;
    gi            = (gc_r > 2'd2) ? 2'd2 : gc_r;
    gcn           = gi + 2'd1;
    complete      = 1'b0;
    cx_adv        = cx_r;
    cy_inc        = cy_r + 16'd1;

    entry      = '0;
    entry.x0   = cx_r;
    entry.x1   = cx_r + 16'd1;
    entry.y    = cy_r;

    if (req_type == REQ_CMD) begin
      cmd_nxt = byte_value;
      bc_nxt  = 3'd0;
      case (byte_value)
        OP_SLEEP_IN, OP_DISP_OFF: st_nxt.sleep  = 1'b1;
        OP_SLEEP_OUT, OP_DISP_ON: st_nxt.sleep  = 1'b0;
        OP_IDLE_ON:               st_nxt.idle   = 1'b1;
        OP_IDLE_OFF:              st_nxt.idle   = 1'b0;
        OP_INV_ON:                st_nxt.invert = 1'b1;
        OP_INV_OFF:               st_nxt.invert = 1'b0;
        OP_SW_RESET:              entry.clr     = 1'b1;
        OP_RAM_WR: begin
          cx_nxt = col_start_r;
          cy_nxt = row_start_r;
          gc_nxt = 2'd0;
        end
        default: ;
      endcase
    end else begin
      case (cmd_r)
        OP_PIX_FMT:  fmt_nxt       = byte_value[2:0];
        OP_SRC_DIR:  st_nxt.flip_x = (byte_value != 8'd0);
        OP_GATE_DIR: st_nxt.flip_y = (byte_value != 8'd0);
        OP_COL_SET: begin
          if (bc_r < 3'd2) begin
            col_start_nxt = put_half(col_start_r, byte_value, bc_r);
          end else if (bc_r < 3'd4) begin
            col_end_nxt = put_half(col_end_r, byte_value, bc_r);
          end
          cx_nxt = col_start_nxt;
        end
        OP_ROW_SET: begin
          if (bc_r < 3'd2) begin
            row_start_nxt = put_half(row_start_r, byte_value, bc_r);
          end else if (bc_r < 3'd4) begin
            row_end_nxt = put_half(row_end_r, byte_value, bc_r);
          end
          cy_nxt = row_start_nxt;
        end
        OP_RAM_WR: begin
          if (gi == 2'd0) gb0_nxt = byte_value;
          if (gi == 2'd1) gb1_nxt = byte_value;
          if (gi == 2'd2) gb2_nxt = byte_value;
          gc_nxt   = gcn;
          complete = ((fmt_r == FMT_16BIT) && (gcn == 2'd2)) || (gcn == 2'd3);
          if (complete) begin
            gc_nxt = 2'd0;
            case (fmt_r)
              FMT_12BIT: begin
                entry.npix = 2'd2;
                entry.r0   = rep4hi(gb0_nxt);
                entry.g0   = rep4lo(gb0_nxt);
                entry.b0   = rep4hi(gb1_nxt);
                entry.r1   = rep4lo(gb1_nxt);
                entry.g1   = rep4hi(gb2_nxt);
                entry.b1   = rep4lo(gb2_nxt);
                cx_adv     = cx_r + 16'd2;
              end
              FMT_16BIT: begin
                entry.npix = 2'd1;
                entry.r0   = {gb0_nxt[7:3], gb0_nxt[7:5]};
                entry.g0   = {gb0_nxt[2:0], gb1_nxt[7:5], gb0_nxt[2:1]};
                entry.b0   = {gb1_nxt[4:0], gb1_nxt[4:2]};
                cx_adv     = cx_r + 16'd1;
              end
              FMT_18BIT: begin
                entry.npix = 2'd1;
                entry.r0   = gb0_nxt;
                entry.g0   = gb1_nxt;
                entry.b0   = gb2_nxt;
                cx_adv     = cx_r + 16'd1;
              end
              default: ;
            endcase
          end
          // wrap inside the window after the advance
          cx_nxt = cx_adv;
          if (cx_adv > col_end_r) begin
            cx_nxt = col_start_r;
            cy_nxt = (cy_inc > row_end_r) ? row_start_r : cy_inc;
          end
        end
        default: ;
      endcase
      if (bc_r < 3'd7) bc_nxt = bc_r + 3'd1;
    end

    entry.st = st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r       <= OP_NONE;
      bc_r        <= 3'd0;
      col_start_r <= 16'd0;
      col_end_r   <= 16'd0;
      row_start_r <= 16'd0;
      row_end_r   <= 16'd0;
      cx_r        <= 16'd0;
      cy_r        <= 16'd0;
      gc_r        <= 2'd0;
      fmt_r       <= FMT_16BIT;
      st_r        <= '0;
    end else if (accept) begin
      cmd_r       <= cmd_nxt;
      bc_r        <= bc_nxt;
      col_start_r <= col_start_nxt;
      col_end_r   <= col_end_nxt;
      row_start_r <= row_start_nxt;
      row_end_r   <= row_end_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      gc_r        <= gc_nxt;
      fmt_r       <= fmt_nxt;
      st_r        <= st_nxt;
    end
  end

  // gathered bytes carry no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      gb0_r <= gb0_nxt;
      gb1_r <= gb1_nxt;
      gb2_r <= gb2_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tdu_queue.sv =====
// tdu_queue: short flop queue of decoded items between front and back
// depends on tdu_pkg for the entry type
`timescale 1ns / 1ps
`default_nettype none

module tdu_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire tdu_pkg::tdu_entry_t wdata,
  output logic                    full,
  input  wire logic               pop,
  output tdu_pkg::tdu_entry_t     rdata,
  output logic                    empty
);
  import tdu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tdu_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wdata;
  end

endmodule

`default_nettype wire

// ===== rtl/tdu_back.sv =====
// tdu_back: frame clipping, address multiply and result sequencing
// depends on tdu_pkg; drains tdu_queue into a one-deep output register
`timescale 1ns / 1ps
`default_nettype none

module tdu_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_empty,
  input  wire tdu_pkg::tdu_entry_t           q_rdata,
  output logic                               q_pop,
  input  wire logic [tdu_pkg::FRAME_DIM_W-1:0] frame_width,
  input  wire logic [tdu_pkg::FRAME_DIM_W-1:0] frame_height,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output tdu_pkg::tdu_result_t               result
);
  import tdu_pkg::*;

  logic [FRAME_DIM_W-1:0] w_eff, h_eff;
  logic [24:0]            prod;
  logic                   v0, v1, y_in;

  logic                   s1_valid_r;
  tdu_entry_t             s1_entry_r;
  logic [15:0]            s1_base_r;
  logic                   s1_v0_r, s1_v1_r, s1_phase_r;

  tdu_result_t            cur;
  logic                   out_valid_r;
  tdu_result_t            out_r;
  logic                   out_load, s1_done;

  always_comb begin
    w_eff = (int'(frame_width) > MAX_WIDTH) ? FRAME_DIM_W'(MAX_WIDTH) : frame_width;
    h_eff = (int'(frame_height) > MAX_HEIGHT) ? FRAME_DIM_W'(MAX_HEIGHT) : frame_height;
    prod  = 25'(q_rdata.y) * 25'(w_eff);
    y_in  = q_rdata.y < {7'd0, h_eff};
    v0    = (q_rdata.npix != 2'd0) && y_in && (q_rdata.x0 < {7'd0, w_eff});
    v1    = (q_rdata.npix == 2'd2) && y_in && (q_rdata.x1 < {7'd0, w_eff});
  end

  // pick the result the staged item gives next
  always_comb begin
    cur             = '0;
    cur.st          = s1_entry_r.st;
    cur.last        = 1'b1;
    if (s1_phase_r || (!s1_v0_r && s1_v1_r)) begin
      cur.pixel_write = 1'b1;
      cur.pixel_addr  = s1_base_r + s1_entry_r.x1;
      cur.red         = s1_entry_r.r1;
      cur.green       = s1_entry_r.g1;
      cur.blue        = s1_entry_r.b1;
    end else if (s1_v0_r) begin
      cur.pixel_write = 1'b1;
      cur.pixel_addr  = s1_base_r + s1_entry_r.x0;
      cur.red         = s1_entry_r.r0;
      cur.green       = s1_entry_r.g0;
      cur.blue        = s1_entry_r.b0;
      cur.last        = !s1_v1_r;
    end else begin
      cur.clear_frame = s1_entry_r.clr;
    end
  end

  assign out_load  = s1_valid_r && (!out_valid_r || out_pop);
  assign s1_done   = out_load && cur.last;
  assign q_pop     = !q_empty && (!s1_valid_r || s1_done);
  assign out_empty = !out_valid_r;
  assign result    = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_phase_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_valid_r <= 1'b1;
        s1_phase_r <= 1'b0;
      end else if (s1_done) begin
        s1_valid_r <= 1'b0;
      end else if (out_load) begin
        s1_phase_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_entry_r <= q_rdata;
      s1_base_r  <= prod[15:0];
      s1_v0_r    <= v0;
      s1_v1_r    <= v1;
    end
    if (out_load) out_r <= cur;
  end

endmodule

`default_nettype wire

// ===== rtl/tft_display_command_pixel_unpacker_top.sv =====
// display write-side decoder: command/data bytes in, frame-buffer writes out.
// Input queue side: push/full with in_req_type (0 command, 1 data) and
// in_byte_value; an item is taken when push is high and full is low.
// Result queue side: empty/pop; the oldest result sits on the out_ ports
// while empty is low and leaves on pop. Each item gives one result (status
// only, or one pixel) or up to two for a 12-bit pixel pair; out_last marks the end.
// The decoder takes one item every cycle while full is low, the output side
// one result a cycle while pop is held; a 12-bit pair adds a result to send.
// A four-entry queue between decoder and output stage absorbs that and any
// receiver stall; full rises only once it fills. Frame width and height are
// set over the APB port (byte address 0 and 4) by the user only while the
// block is idle; the block itself does not enforce it. Reset (rst_n low,
// synchronous) empties both queues, restores width 128, height 160, 16-bit
// format and clears status.
// files: tdu_pkg, tdu_front, tdu_queue, tdu_back
`timescale 1ns / 1ps
`default_nettype none

module tft_display_command_pixel_unpacker_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          in_req_type,
  input  wire logic [7:0]                    in_byte_value,
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               out_pixel_write,
  output logic [15:0]                        out_pixel_addr,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  output logic                               out_last,
  output logic                               out_clear_frame,
  output logic                               out_sleep_flag,
  output logic                               out_idle_flag,
  output logic                               out_invert_flag,
  output logic                               out_flip_x,
  output logic                               out_flip_y,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tdu_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [tdu_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tdu_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import tdu_pkg::*;

  logic [FRAME_DIM_W-1:0] fw_r, fw_nxt, fh_r, fh_nxt;
  logic                   cfg_wr;
  logic                   accept;
  tdu_entry_t             f_entry, q_entry;
  logic                   q_empty, q_pop;
  tdu_result_t            res;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    fw_nxt = fw_r;
    fh_nxt = fh_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  fw_nxt = pwdata[FRAME_DIM_W-1:0];
        REG_FRAME_HEIGHT: fh_nxt = pwdata[FRAME_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(fw_r);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(fh_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FRAME_WIDTH_RST;
      fh_r <= FRAME_HEIGHT_RST;
    end else begin
      fw_r <= fw_nxt;
      fh_r <= fh_nxt;
    end
  end

  assign accept = push && !full;

  tdu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .req_type   (in_req_type),
    .byte_value (in_byte_value),
    .entry      (f_entry)
  );

  tdu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (f_entry),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_entry),
    .empty (q_empty)
  );

  tdu_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_rdata      (q_entry),
    .q_pop        (q_pop),
    .frame_width  (fw_r),
    .frame_height (fh_r),
    .out_empty    (empty),
    .out_pop      (pop),
    .result       (res)
  );

  assign out_pixel_write = res.pixel_write;
  assign out_pixel_addr  = res.pixel_addr;
  assign out_red         = res.red;
  assign out_green       = res.green;
  assign out_blue        = res.blue;
  assign out_last        = res.last;
  assign out_clear_frame = res.clear_frame;
  assign out_sleep_flag  = res.st.sleep;
  assign out_idle_flag   = res.st.idle;
  assign out_invert_flag = res.st.invert;
  assign out_flip_x      = res.st.flip_x;
  assign out_flip_y      = res.st.flip_y;

endmodule

`default_nettype wire

// ===== bench/tb_tft_display_command_pixel_unpacker_top.sv =====
// self-checking bench for the tft display command and pixel unpacker
// depends on tdu_pkg and tft_display_command_pixel_unpacker_top
// a built-in decoder predicts results
`timescale 1ns / 1ps

module tb_tft_display_command_pixel_unpacker_top;
  import tdu_pkg::*;

  typedef struct packed {
    logic       req_type;
    logic [7:0] value;
  } link_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        in_req_type = REQ_CMD;
  logic [7:0]  in_byte_value = 8'd0;
  logic        pop = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic        full, empty, pready;
  logic [CFG_DATA_W-1:0] prdata;
  logic        out_pixel_write, out_last, out_clear_frame;
  logic [15:0] out_pixel_addr;
  logic [7:0]  out_red, out_green, out_blue;
  logic        out_sleep_flag, out_idle_flag, out_invert_flag, out_flip_x, out_flip_y;

  tft_display_command_pixel_unpacker_top dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_req_type(in_req_type), .in_byte_value(in_byte_value),
    .empty(empty), .pop(pop),
    .out_pixel_write(out_pixel_write), .out_pixel_addr(out_pixel_addr),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_last(out_last), .out_clear_frame(out_clear_frame),
    .out_sleep_flag(out_sleep_flag), .out_idle_flag(out_idle_flag),
    .out_invert_flag(out_invert_flag), .out_flip_x(out_flip_x), .out_flip_y(out_flip_y),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder state kept by the bench
  logic [8:0]  frame_w, frame_h;
  logic [7:0]  cur_cmd;
  logic [2:0]  byte_cnt;
  logic [15:0] col_start, col_end, row_start, row_end, cur_x, cur_y;
  logic [1:0]  gath_cnt;
  logic [7:0]  gath [3];
  logic [2:0]  pix_fmt;
  tdu_status_t disp_st;

  link_byte_t  byte_queue [$];
  tdu_result_t step_results [$];
  tdu_result_t results_due [$];

  link_byte_t  tx_item;
  int          tx_hold = 0, rx_hold = 0;
  bit          tx_calm = 1'b0, rx_calm = 1'b0;
  int          fail_count = 0, items_taken = 0, results_seen = 0;
  int          pixels_seen = 0, clears_seen = 0;

  function automatic int draw_idle(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic [15:0] load_half(input logic [15:0] word, input logic [7:0] b,
                                            input logic low_half);
    return low_half ? {word[15:8], b} : {b, word[7:0]};
  endfunction

  function automatic void emit_pixel(input logic [15:0] x, input logic [15:0] y,
                                     input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b);
    int unsigned w, h, addr;
    tdu_result_t res;
    w = (frame_w > MAX_WIDTH) ? MAX_WIDTH : frame_w;
    h = (frame_h > MAX_HEIGHT) ? MAX_HEIGHT : frame_h;
    if (x >= w || y >= h) return;
    addr = y * w + x;
    res = '0;
    res.pixel_write = 1'b1;
    res.pixel_addr = addr[15:0];
    res.red = r;
    res.green = g;
    res.blue = b;
    step_results.push_back(res);
  endfunction

  task automatic reset_display_model();
    frame_w = FRAME_WIDTH_RST;
    frame_h = FRAME_HEIGHT_RST;
    cur_cmd = OP_NONE;
    byte_cnt = '0;
    {col_start, col_end, row_start, row_end, cur_x, cur_y} = '0;
    gath_cnt = '0;
    gath = '{8'd0, 8'd0, 8'd0};
    pix_fmt = FMT_16BIT;
    disp_st = '0;
  endtask

  // works out every result one accepted byte causes
  task automatic decode_display_byte(input logic is_data, input logic [7:0] v);
    logic        clr;
    logic [1:0]  gi;
    tdu_result_t res;
    clr = 1'b0;
    step_results.delete();
    if (is_data == REQ_CMD) begin
      cur_cmd = v;
      byte_cnt = '0;
      case (v)
        OP_SLEEP_IN, OP_DISP_OFF: disp_st.sleep = 1'b1;
        OP_SLEEP_OUT, OP_DISP_ON: disp_st.sleep = 1'b0;
        OP_IDLE_ON:  disp_st.idle = 1'b1;
        OP_IDLE_OFF: disp_st.idle = 1'b0;
        OP_INV_ON:   disp_st.invert = 1'b1;
        OP_INV_OFF:  disp_st.invert = 1'b0;
        OP_SW_RESET: clr = 1'b1;
        OP_RAM_WR: begin
          cur_x = col_start;
          cur_y = row_start;
          gath_cnt = '0;
        end
        default: ;
      endcase
    end else begin
      case (cur_cmd)
        OP_PIX_FMT:  pix_fmt = v[2:0];
        OP_SRC_DIR:  disp_st.flip_x = (v != 8'd0);
        OP_GATE_DIR: disp_st.flip_y = (v != 8'd0);
        OP_COL_SET: begin
          if (byte_cnt < 3'd2) col_start = load_half(col_start, v, byte_cnt[0]);
          else if (byte_cnt < 3'd4) col_end = load_half(col_end, v, byte_cnt[0]);
          cur_x = col_start;
        end
        OP_ROW_SET: begin
          if (byte_cnt < 3'd2) row_start = load_half(row_start, v, byte_cnt[0]);
          else if (byte_cnt < 3'd4) row_end = load_half(row_end, v, byte_cnt[0]);
          cur_y = row_start;
        end
        OP_RAM_WR: begin
          gi = (gath_cnt > 2'd2) ? 2'd2 : gath_cnt;
          gath[gi] = v;
          gath_cnt = gi + 2'd1;
          if ((pix_fmt == FMT_16BIT && gath_cnt == 2'd2) || gath_cnt == 2'd3) begin
            case (pix_fmt)
              FMT_12BIT: begin
                emit_pixel(cur_x, cur_y, {2{gath[0][7:4]}}, {2{gath[0][3:0]}},
                           {2{gath[1][7:4]}});
                // second pixel of the pair ignores the column end
                emit_pixel(cur_x + 16'd1, cur_y, {2{gath[1][3:0]}}, {2{gath[2][7:4]}},
                           {2{gath[2][3:0]}});
                cur_x = cur_x + 16'd2;
              end
              FMT_16BIT: begin
                emit_pixel(cur_x, cur_y, {gath[0][7:3], gath[0][7:5]},
                           {gath[0][2:0], gath[1][7:5], gath[0][2:1]},
                           {gath[1][4:0], gath[1][4:2]});
                cur_x = cur_x + 16'd1;
              end
              FMT_18BIT: begin
                emit_pixel(cur_x, cur_y, gath[0], gath[1], gath[2]);
                cur_x = cur_x + 16'd1;
              end
              default: ;  // unknown format: bytes dropped, cursor stays
            endcase
            gath_cnt = '0;
          end
          if (cur_x > col_end) begin
            cur_x = col_start;
            cur_y = cur_y + 16'd1;
            if (cur_y > row_end) cur_y = row_start;
          end
        end
        default: ;
      endcase
      if (byte_cnt < 3'd7) byte_cnt = byte_cnt + 3'd1;
    end
    if (step_results.size() == 0) begin
      res = '0;
      res.clear_frame = clr;
      step_results.push_back(res);
    end
    foreach (step_results[k]) begin
      step_results[k].st = disp_st;
      step_results[k].last = (k == step_results.size() - 1);
      results_due.push_back(step_results[k]);
    end
  endtask

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  task automatic check_result();
    tdu_result_t want;
    results_seen++;
    if (results_due.size() == 0) begin
      fail_count++;
      $display("%0t: result with nothing outstanding, expected none, actual addr %h write %b",
               $time, out_pixel_addr, out_pixel_write);
    end else begin
      want = results_due.pop_front();
      if (want.pixel_write) pixels_seen++;
      if (want.clear_frame) clears_seen++;
      compare_field("pixel_write", 16'(want.pixel_write), 16'(out_pixel_write));
      compare_field("pixel_addr", want.pixel_addr, out_pixel_addr);
      compare_field("red", 16'(want.red), 16'(out_red));
      compare_field("green", 16'(want.green), 16'(out_green));
      compare_field("blue", 16'(want.blue), 16'(out_blue));
      compare_field("last", 16'(want.last), 16'(out_last));
      compare_field("clear_frame", 16'(want.clear_frame), 16'(out_clear_frame));
      compare_field("sleep_flag", 16'(want.st.sleep), 16'(out_sleep_flag));
      compare_field("idle_flag", 16'(want.st.idle), 16'(out_idle_flag));
      compare_field("invert_flag", 16'(want.st.invert), 16'(out_invert_flag));
      compare_field("flip_x", 16'(want.st.flip_x), 16'(out_flip_x));
      compare_field("flip_y", 16'(want.st.flip_y), 16'(out_flip_y));
    end
  endtask

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      tx_hold = 0;
    end else begin
      if (push && !full) begin
        decode_display_byte(in_req_type, in_byte_value);
        items_taken++;
      end
      if (!(push && full)) begin
        if (tx_hold > 0) begin
          push <= 1'b0;
          tx_hold--;
        end else if (byte_queue.size() != 0) begin
          tx_item = byte_queue.pop_front();
          push <= 1'b1;
          in_req_type <= tx_item.req_type;
          in_byte_value <= tx_item.value;
          tx_hold = draw_idle(tx_calm);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      rx_hold = 0;
    end else begin
      if (pop && !empty) begin
        check_result();
        rx_hold = draw_idle(rx_calm);
      end
      if (rx_hold > 0) begin
        pop <= 1'b0;
        rx_hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic queue_cmd(input logic [7:0] op);
    byte_queue.push_back('{REQ_CMD, op});
  endtask

  task automatic queue_data(input logic [7:0] v);
    byte_queue.push_back('{REQ_DATA, v});
  endtask

  task automatic queue_window(input logic [7:0] op, input logic [15:0] lo,
                              input logic [15:0] hi);
    queue_cmd(op);
    queue_data(lo[15:8]);
    queue_data(lo[7:0]);
    queue_data(hi[15:8]);
    queue_data(hi[7:0]);
    if ($urandom_range(0, 9) == 0) queue_data(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [15:0] pick_coord(input int unsigned span);
    case ($urandom_range(0, 15))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'hFFFF - 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(0, span + 3));
    endcase
  endfunction

  task automatic queue_random_sequence();
    logic [7:0]  status_ops [9];
    logic [15:0] lo;
    int unsigned w_span, h_span, pick;
    status_ops = '{OP_SW_RESET, OP_SLEEP_IN, OP_SLEEP_OUT, OP_INV_OFF, OP_INV_ON,
                   OP_DISP_OFF, OP_DISP_ON, OP_IDLE_OFF, OP_IDLE_ON};
    w_span = (frame_w > MAX_WIDTH) ? MAX_WIDTH : frame_w;
    h_span = (frame_h > MAX_HEIGHT) ? MAX_HEIGHT : frame_h;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      // drawing burst: optional window and format, then pixel bytes
      if ($urandom_range(0, 2) != 0) begin
        lo = pick_coord(w_span);
        queue_window(OP_COL_SET, lo, ($urandom_range(0, 5) == 0) ? pick_coord(w_span)
                                                : lo + 16'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 2) != 0) begin
        lo = pick_coord(h_span);
        queue_window(OP_ROW_SET, lo, ($urandom_range(0, 5) == 0) ? pick_coord(h_span)
                                                : lo + 16'($urandom_range(0, 6)));
      end
      if ($urandom_range(0, 2) == 0) begin
        queue_cmd(OP_PIX_FMT);
        case ($urandom_range(0, 6))
          0, 1:    queue_data({5'($urandom_range(0, 31)), FMT_12BIT});
          2, 3:    queue_data({5'($urandom_range(0, 31)), FMT_16BIT});
          4, 5:    queue_data({5'($urandom_range(0, 31)), FMT_18BIT});
          default: queue_data(8'($urandom_range(0, 255)));
        endcase
      end
      queue_cmd(OP_RAM_WR);
      repeat ($urandom_range(1, 30)) queue_data(8'($urandom_range(0, 255)));
    end else if (pick < 65) begin
      queue_cmd(status_ops[$urandom_range(0, 8)]);
    end else if (pick < 72) begin
      queue_cmd($urandom_range(0, 1) ? OP_SRC_DIR : OP_GATE_DIR);
      queue_data($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255)));
    end else if (pick < 80) begin
      // window with one to seven bytes, so often too few or too many
      queue_cmd($urandom_range(0, 1) ? OP_COL_SET : OP_ROW_SET);
      repeat ($urandom_range(1, 7)) queue_data(8'($urandom_range(0, 255)));
    end else begin
      queue_cmd(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 3)) queue_data(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic apb_xfer(input logic is_write, input logic reg_sel,
                          input logic [CFG_DATA_W-1:0] wdata);
    logic [8:0] want;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= {reg_sel, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (!is_write) begin
      want = (reg_sel == REG_FRAME_HEIGHT) ? frame_h : frame_w;
      if (prdata !== {{(CFG_DATA_W-9){1'b0}}, want}) begin
        fail_count++;
        $display("%0t: register %0d readback, expected %h, actual %h", $time, reg_sel,
                 want, prdata);
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_frame(input logic [8:0] w, input logic [8:0] h);
    apb_xfer(1'b1, REG_FRAME_WIDTH, {23'($urandom), w});
    frame_w = w;
    apb_xfer(1'b1, REG_FRAME_HEIGHT, {23'($urandom), h});
    frame_h = h;
    apb_xfer(1'b0, REG_FRAME_WIDTH, '0);
    apb_xfer(1'b0, REG_FRAME_HEIGHT, '0);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (byte_queue.size() != 0 || push || results_due.size() != 0);
  endtask

  initial begin
    int unsigned phase_w [8];
    int unsigned phase_h [8];
    phase_w = '{128, 256, 1, 511, 0, 200, 17, 0};
    phase_h = '{160, 256, 1, 300, 37, 100, 256, 0};
    reset_display_model();

    // directed opening: clear, every status command, flips, window edge cases, 12-bit pair
    queue_cmd(OP_SW_RESET);
    queue_cmd(OP_SLEEP_IN);
    queue_cmd(OP_DISP_ON);
    queue_cmd(OP_DISP_OFF);
    queue_cmd(OP_SLEEP_OUT);
    queue_cmd(OP_INV_ON);
    queue_cmd(OP_IDLE_ON);
    queue_cmd(OP_SRC_DIR);
    queue_data(8'hFF);
    queue_cmd(OP_GATE_DIR);
    queue_data(8'h01);
    queue_cmd(OP_COL_SET);
    queue_data(8'h00);
    queue_data(8'h7E);
    queue_data(8'h00);
    queue_data(8'h80);
    queue_data(8'hFF);  // beyond the fourth byte, ignored
    queue_cmd(OP_PIX_FMT);
    queue_data({5'd0, FMT_12BIT});
    queue_cmd(OP_RAM_WR);
    queue_data(8'hAB);
    queue_data(8'hCD);
    queue_data(8'hEF);
    // pair lands on column 128 and past the column end, both outside the frame
    queue_data(8'h12);
    queue_data(8'h34);
    queue_data(8'h56);
    queue_cmd(OP_INV_OFF);
    queue_cmd(OP_IDLE_OFF);
    queue_cmd(8'hFF);
    queue_data(8'h00);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      if (p == 7) begin
        phase_w[p] = $urandom_range(0, 511);
        phase_h[p] = $urandom_range(0, 511);
      end
      if (p > 0) set_frame(9'(phase_w[p]), 9'(phase_h[p]));
      @(negedge clk);
      while (byte_queue.size() < 118) queue_random_sequence();
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d bytes giving %0d results: %0d pixel writes, %0d frame clears,",
             items_taken, results_seen, pixels_seen, clears_seen);
    $display("across 8 frame size settings including zero, one and oversize");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", results_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tdu_pkg.sv
rtl/tdu_front.sv
rtl/tdu_queue.sv
rtl/tdu_back.sv
rtl/tft_display_command_pixel_unpacker_top.sv
bench/tb_tft_display_command_pixel_unpacker_top.sv
